[sv/icw_pkg.sv]
// shared constants, types and state codes of the coherence window block
`default_nettype none
package icw_pkg;

  // sizes of the image and the window
  localparam int MAX_LINE_SAMPLES   = 4096;
  localparam int MAX_WINDOW_SAMPLES = 16;
  localparam int SAMPLE_BITS        = 16;

  localparam int COL_W    = $clog2(MAX_LINE_SAMPLES);
  localparam int LW_W     = 13;
  localparam int LOOK_W   = 5;
  localparam int STEP_W   = 5;
  localparam int RECENT_W = $clog2(MAX_WINDOW_SAMPLES);

  // column sums and window sums
  localparam int TERM_W        = 2 * SAMPLE_BITS + 1;
  localparam int POWER_TERM_W  = 2 * SAMPLE_BITS;
  localparam int CROSS_W       = 40;
  localparam int POWER_W       = 39;
  localparam int WSUM_CROSS_W  = CROSS_W + RECENT_W;
  localparam int WSUM_POWER_W  = POWER_W + RECENT_W;

  // coherence arithmetic
  localparam int MAG_W      = WSUM_CROSS_W;
  localparam int NUM_W      = 2 * MAG_W;
  localparam int DEN_W      = 2 * WSUM_POWER_W;
  localparam int MUL_A_W    = NUM_W;
  localparam int MUL_B_W    = MAG_W;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int MUL_DIGIT  = 4;
  localparam int MUL_STEPS  = (MUL_B_W + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int Q_W        = 16;
  localparam int Q_FRAC     = 15;
  localparam int ROOT_SHIFT = 2 * Q_FRAC;
  localparam int ROOT_W     = NUM_W + ROOT_SHIFT + 2;
  localparam int BIT_IDX_W  = $clog2(Q_FRAC);
  localparam int OVER_NUM_K = 100000000;
  localparam int OVER_DEN_K = 100020001;
  localparam logic [Q_W-1:0] ONE_Q15 = Q_W'(1 << Q_FRAC);

  // register reset values
  localparam logic [LW_W-1:0]   LINE_WIDTH_RST = LW_W'(1024);
  localparam logic [LOOK_W-1:0] LOOK_RST       = LOOK_W'(3);
  localparam logic [STEP_W-1:0] STEP_RST       = STEP_W'(1);

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LW_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOK_SAMPLES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SAMPLES = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] first_real;
    logic signed [SAMPLE_BITS-1:0] first_imag;
    logic signed [SAMPLE_BITS-1:0] second_real;
    logic signed [SAMPLE_BITS-1:0] second_imag;
    logic                          final_row;
  } sample_t;

  typedef struct packed {
    logic [Q_W-1:0]   coherence;
    logic [COL_W-1:0] out_column;
    logic             over_one;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic signed [CROSS_W-1:0] cross_real;
    logic signed [CROSS_W-1:0] cross_imag;
    logic [POWER_W-1:0]        power_first;
    logic [POWER_W-1:0]        power_second;
  } col_sums_t;

  typedef struct packed {
    logic signed [WSUM_CROSS_W-1:0] cross_real;
    logic signed [WSUM_CROSS_W-1:0] cross_imag;
    logic [WSUM_POWER_W-1:0]        power_first;
    logic [WSUM_POWER_W-1:0]        power_second;
  } win_sums_t;

  typedef struct packed {
    logic [Q_W-1:0] q;
    logic           over;
  } coh_res_t;

  typedef enum logic [3:0] {
    T_IDLE, T_MUL, T_ACC, T_MOD, T_FIRST, T_SUM, T_START, T_WAIT, T_OUT
  } top_state_e;

  typedef enum logic [3:0] {
    C_IDLE, C_SQR, C_SQI, C_DEN, C_OVN, C_OVD, C_CAND, C_CMP, C_DONE
  } coh_state_e;

endpackage
`default_nettype wire

[sv/icw_sample_if.sv]
// sample pair channel
`default_nettype none
interface icw_sample_if;
  logic              valid;
  logic              ready;
  icw_pkg::sample_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/icw_result_if.sv]
// coherence result channel
`default_nettype none
interface icw_result_if;
  logic              valid;
  logic              ready;
  icw_pkg::result_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/icw_column_ram.sv]
// single port write, single port read column sum memory with registered read
`default_nettype none
module icw_column_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 158
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[sv/icw_serial_mul.sv]
// digit serial unsigned multiplier, four multiplier bits per cycle
`default_nettype none
module icw_serial_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [icw_pkg::MUL_A_W-1:0] a_i,
  input  logic [icw_pkg::MUL_B_W-1:0] b_i,
  output logic                        done_o,
  output logic [icw_pkg::PROD_W-1:0]  prod_o
);

  localparam int CNT_W = $clog2(icw_pkg::MUL_STEPS);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [icw_pkg::PROD_W-1:0]  acc_q;
  logic [icw_pkg::PROD_W-1:0]  ash_q;
  logic [icw_pkg::MUL_B_W-1:0] b_q;
  logic [icw_pkg::PROD_W-1:0]  part;

  // partial product of one digit
  always_comb begin
    part = '0;
    for (int k = 0; k < icw_pkg::MUL_DIGIT; k++) begin
      if (b_q[k]) begin
        part = part + (ash_q << k);
      end
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(icw_pkg::MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift and accumulate
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ash_q <= icw_pkg::PROD_W'(a_i);
      b_q   <= b_i;
    end else if (busy_q) begin
      acc_q <= acc_q + part;
      ash_q <= ash_q << icw_pkg::MUL_DIGIT;
      b_q   <= b_q >> icw_pkg::MUL_DIGIT;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

[sv/icw_coh_unit.sv]
// coherence of one window: exact magnitude test and bitwise square root
`default_nettype none
module icw_coh_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  icw_pkg::win_sums_t  sums_i,
  output logic                done_o,
  output icw_pkg::coh_res_t   res_o
);

  icw_pkg::coh_state_e st_q, st_d;

  logic [icw_pkg::MAG_W-1:0]     mag_r, mag_i;
  logic                          mul_start, mul_done;
  logic [icw_pkg::MUL_A_W-1:0]   mul_a;
  logic [icw_pkg::MUL_B_W-1:0]   mul_b;
  logic [icw_pkg::PROD_W-1:0]    prod;
  logic [icw_pkg::NUM_W-1:0]     num_q;
  logic [icw_pkg::DEN_W-1:0]     den_q;
  logic [icw_pkg::PROD_W-1:0]    lhs_q;
  logic [icw_pkg::Q_FRAC-1:0]    acc_q, acc_set;
  logic [icw_pkg::ROOT_W-1:0]    sq_q, da_q, cand_q, rhs, den_w;
  logic [icw_pkg::BIT_IDX_W-1:0] bit_idx_q;
  icw_pkg::coh_res_t             res_q;
  logic                          den_zero;

  // magnitudes of the cross sums
  assign mag_r = sums_i.cross_real[icw_pkg::WSUM_CROSS_W-1] ?
                 icw_pkg::MAG_W'(-sums_i.cross_real) : icw_pkg::MAG_W'(sums_i.cross_real);
  assign mag_i = sums_i.cross_imag[icw_pkg::WSUM_CROSS_W-1] ?
                 icw_pkg::MAG_W'(-sums_i.cross_imag) : icw_pkg::MAG_W'(sums_i.cross_imag);
  assign den_zero = (sums_i.power_first == '0) || (sums_i.power_second == '0);

  assign rhs     = icw_pkg::ROOT_W'({num_q, {icw_pkg::ROOT_SHIFT{1'b0}}});
  assign den_w   = icw_pkg::ROOT_W'(den_q);
  assign acc_set = acc_q | (icw_pkg::Q_FRAC'(1) << bit_idx_q);

  icw_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= icw_pkg::C_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // next state and multiplier issue
  always_comb begin
    st_d      = st_q;
    mul_start = 1'b0;
    mul_a     = icw_pkg::MUL_A_W'(mag_r);
    mul_b     = mag_r;
    done_o    = 1'b0;
    unique case (st_q)
      icw_pkg::C_IDLE: begin
        if (start_i) begin
          if (den_zero) begin
            st_d = icw_pkg::C_DONE;
          end else begin
            mul_start = 1'b1;
            st_d      = icw_pkg::C_SQR;
          end
        end
      end
      icw_pkg::C_SQR: begin
        mul_a = icw_pkg::MUL_A_W'(mag_i);
        mul_b = mag_i;
        if (mul_done) begin
          mul_start = 1'b1;
          st_d      = icw_pkg::C_SQI;
        end
      end
      icw_pkg::C_SQI: begin
        mul_a = icw_pkg::MUL_A_W'(sums_i.power_first);
        mul_b = icw_pkg::MUL_B_W'(sums_i.power_second);
        if (mul_done) begin
          mul_start = 1'b1;
          st_d      = icw_pkg::C_DEN;
        end
      end
      icw_pkg::C_DEN: begin
        mul_a = num_q;
        mul_b = icw_pkg::MUL_B_W'(icw_pkg::OVER_NUM_K);
        if (mul_done) begin
          mul_start = 1'b1;
          st_d      = icw_pkg::C_OVN;
        end
      end
      icw_pkg::C_OVN: begin
        mul_a = icw_pkg::MUL_A_W'(den_q);
        mul_b = icw_pkg::MUL_B_W'(icw_pkg::OVER_DEN_K);
        if (mul_done) begin
          mul_start = 1'b1;
          st_d      = icw_pkg::C_OVD;
        end
      end
      icw_pkg::C_OVD: begin
        if (mul_done) begin
          if ((lhs_q > prod) || (icw_pkg::NUM_W'(den_q) <= num_q)) begin
            st_d = icw_pkg::C_DONE;
          end else begin
            st_d = icw_pkg::C_CAND;
          end
        end
      end
      icw_pkg::C_CAND: st_d = icw_pkg::C_CMP;
      icw_pkg::C_CMP: begin
        st_d = (bit_idx_q == '0) ? icw_pkg::C_DONE : icw_pkg::C_CAND;
      end
      icw_pkg::C_DONE: begin
        done_o = 1'b1;
        st_d   = icw_pkg::C_IDLE;
      end
      default: st_d = icw_pkg::C_IDLE;
    endcase
  end

  // datapath registers, result held until the next start
  always_ff @(posedge clk_i) begin
    case (st_q)
      icw_pkg::C_IDLE: begin
        if (start_i) res_q <= '0;
      end
      icw_pkg::C_SQR: begin
        if (mul_done) num_q <= prod[icw_pkg::NUM_W-1:0];
      end
      icw_pkg::C_SQI: begin
        if (mul_done) num_q <= num_q + prod[icw_pkg::NUM_W-1:0];
      end
      icw_pkg::C_DEN: begin
        if (mul_done) den_q <= prod[icw_pkg::DEN_W-1:0];
      end
      icw_pkg::C_OVN: begin
        if (mul_done) lhs_q <= prod;
      end
      icw_pkg::C_OVD: begin
        if (mul_done) begin
          if (lhs_q > prod) begin
            res_q.q    <= icw_pkg::ONE_Q15;
            res_q.over <= 1'b1;
          end else if (icw_pkg::NUM_W'(den_q) <= num_q) begin
            res_q.q    <= icw_pkg::ONE_Q15;
            res_q.over <= 1'b0;
          end
          acc_q     <= '0;
          sq_q      <= '0;
          da_q      <= '0;
          bit_idx_q <= icw_pkg::BIT_IDX_W'(icw_pkg::Q_FRAC - 1);
        end
      end
      icw_pkg::C_CAND: begin
        cand_q <= sq_q + (da_q << (bit_idx_q + 1'b1)) + (den_w << {bit_idx_q, 1'b0});
      end
      icw_pkg::C_CMP: begin
        if (cand_q <= rhs) begin
          acc_q <= acc_set;
          sq_q  <= cand_q;
          da_q  <= da_q + (den_w << bit_idx_q);
        end
        if (bit_idx_q == '0) begin
          res_q.q    <= icw_pkg::Q_W'((cand_q <= rhs) ? acc_set : acc_q);
          res_q.over <= 1'b0;
        end else begin
          bit_idx_q <= bit_idx_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

[sv/interferogram_coherence_window.sv]
// top level of the boxcar coherence estimator
// an item that closes no window passes through accept, multiply and read-modify-write
// a closing item adds a start phase on the step grid, then per window a sum over its columns,
// the serial multiplier and square root loop, and the output transfer
// one item at a time; the next sample is taken once the last result has gone out
// reset clears control, registers and the recent columns; the column memory is not cleared
`default_nettype none
module interferogram_coherence_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [icw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [icw_pkg::CFG_DATA_W-1:0] cfg_data_i,
  icw_sample_if.sink                    sample_i,
  icw_result_if.source                  result_o
);

  localparam int LW_W   = icw_pkg::LW_W;
  localparam int COL_W  = icw_pkg::COL_W;
  localparam int RW     = icw_pkg::RECENT_W;
  localparam int NREC   = icw_pkg::MAX_WINDOW_SAMPLES;
  localparam int MBIT_W = $clog2(COL_W);
  localparam int CROSS_W_P1 = icw_pkg::CROSS_W + 1;

  icw_pkg::top_state_e st_q, st_d;

  logic [LW_W-1:0]               lw_q;
  logic [icw_pkg::LOOK_W-1:0]    look_q;
  logic [icw_pkg::STEP_W-1:0]    step_q;
  logic [LW_W-1:0]               w_eff;
  logic [icw_pkg::LOOK_W-1:0]    l_eff;
  logic [icw_pkg::STEP_W-1:0]    st_eff;

  logic [COL_W-1:0]              col_q, c_q, c_sel;
  logic                          first_q;
  icw_pkg::sample_t              smp_q;
  logic signed [icw_pkg::TERM_W-1:0] xr_t_q, xi_t_q;
  logic [icw_pkg::POWER_TERM_W-1:0]  p1_t_q, p2_t_q;
  icw_pkg::col_sums_t            rec_q [NREC];
  icw_pkg::col_sums_t            ram_rd, base, tot;
  logic                          ram_re, ram_we;

  logic [COL_W-1:0]              s0_q, send_q, idx_q;
  logic [icw_pkg::STEP_W-1:0]    rem_q, rem_n;
  logic [icw_pkg::STEP_W:0]      rem_x;
  logic [MBIT_W-1:0]             mbit_q;
  logic [LW_W-1:0]               s_q, s_first, s_next, c1;
  logic                          plan_emit, last_run;
  logic [COL_W-1:0]              plan_s0, plan_send;
  icw_pkg::win_sums_t            sums_q;
  logic                          coh_start, coh_done;
  icw_pkg::coh_res_t             coh_res;

  logic signed [2*icw_pkg::SAMPLE_BITS-1:0] m_rr, m_ii, m_ir, m_ri, m_aa, m_ab, m_bb, m_bi;
  logic signed [CROSS_W_P1-1:0]  xr_sum, xi_sum;
  logic [icw_pkg::POWER_W:0]     p1_sum, p2_sum;

  // effective register values
  always_comb begin
    w_eff  = (lw_q == '0) ? LW_W'(1) :
             (lw_q > LW_W'(icw_pkg::MAX_LINE_SAMPLES)) ? LW_W'(icw_pkg::MAX_LINE_SAMPLES) : lw_q;
    l_eff  = (look_q == '0) ? icw_pkg::LOOK_W'(1) :
             (look_q > icw_pkg::LOOK_W'(NREC)) ? icw_pkg::LOOK_W'(NREC) : look_q;
    st_eff = (step_q == '0) ? icw_pkg::STEP_W'(1) : step_q;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q   <= icw_pkg::LINE_WIDTH_RST;
      look_q <= icw_pkg::LOOK_RST;
      step_q <= icw_pkg::STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        icw_pkg::CFG_LINE_WIDTH:   lw_q   <= cfg_data_i;
        icw_pkg::CFG_LOOK_SAMPLES: look_q <= cfg_data_i[icw_pkg::LOOK_W-1:0];
        icw_pkg::CFG_STEP_SAMPLES: step_q <= cfg_data_i[icw_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign c_sel = ({1'b0, col_q} >= w_eff) ? '0 : col_q;

  // per-column sum memory
  icw_column_ram #(
    .DEPTH (icw_pkg::MAX_LINE_SAMPLES),
    .WIDTH ($bits(icw_pkg::col_sums_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_q),
    .wdata_i (tot),
    .re_i    (ram_re),
    .raddr_i (c_sel),
    .rdata_o (ram_rd)
  );

  // sample products
  always_comb begin
    m_rr = smp_q.first_real * smp_q.second_real;
    m_ii = smp_q.first_imag * smp_q.second_imag;
    m_ir = smp_q.first_imag * smp_q.second_real;
    m_ri = smp_q.first_real * smp_q.second_imag;
    m_aa = smp_q.first_real * smp_q.first_real;
    m_ab = smp_q.first_imag * smp_q.first_imag;
    m_bb = smp_q.second_real * smp_q.second_real;
    m_bi = smp_q.second_imag * smp_q.second_imag;
  end

  // column total with saturation
  always_comb begin
    base   = first_q ? '0 : ram_rd;
    xr_sum = {base.cross_real[icw_pkg::CROSS_W-1], base.cross_real} +
             {{(CROSS_W_P1 - icw_pkg::TERM_W){xr_t_q[icw_pkg::TERM_W-1]}}, xr_t_q};
    xi_sum = {base.cross_imag[icw_pkg::CROSS_W-1], base.cross_imag} +
             {{(CROSS_W_P1 - icw_pkg::TERM_W){xi_t_q[icw_pkg::TERM_W-1]}}, xi_t_q};
    p1_sum = {1'b0, base.power_first} + (icw_pkg::POWER_W + 1)'(p1_t_q);
    p2_sum = {1'b0, base.power_second} + (icw_pkg::POWER_W + 1)'(p2_t_q);
    tot.cross_real = (xr_sum[icw_pkg::CROSS_W] != xr_sum[icw_pkg::CROSS_W-1]) ?
                     {xr_sum[icw_pkg::CROSS_W], {(icw_pkg::CROSS_W-1){~xr_sum[icw_pkg::CROSS_W]}}} :
                     xr_sum[icw_pkg::CROSS_W-1:0];
    tot.cross_imag = (xi_sum[icw_pkg::CROSS_W] != xi_sum[icw_pkg::CROSS_W-1]) ?
                     {xi_sum[icw_pkg::CROSS_W], {(icw_pkg::CROSS_W-1){~xi_sum[icw_pkg::CROSS_W]}}} :
                     xi_sum[icw_pkg::CROSS_W-1:0];
    tot.power_first  = p1_sum[icw_pkg::POWER_W] ? '1 : p1_sum[icw_pkg::POWER_W-1:0];
    tot.power_second = p2_sum[icw_pkg::POWER_W] ? '1 : p2_sum[icw_pkg::POWER_W-1:0];
  end

  // which windows the current column closes
  always_comb begin
    c1        = LW_W'(c_q) + LW_W'(1);
    plan_emit = 1'b0;
    plan_s0   = '0;
    plan_send = '0;
    if (smp_q.final_row) begin
      if (c1 < w_eff) begin
        if (c1 >= LW_W'(l_eff)) begin
          plan_emit = 1'b1;
          plan_s0   = COL_W'(c1 - LW_W'(l_eff));
          plan_send = COL_W'(c1 - LW_W'(l_eff));
        end
      end else begin
        plan_emit = 1'b1;
        plan_s0   = (w_eff > LW_W'(l_eff)) ? COL_W'(w_eff - LW_W'(l_eff)) : '0;
        plan_send = c_q;
      end
    end
  end

  // remainder step, first start on the step grid, window walk
  always_comb begin
    rem_x = {rem_q, s0_q[mbit_q]};
    if (rem_x >= {1'b0, st_eff}) rem_x = rem_x - {1'b0, st_eff};
    rem_n    = rem_x[icw_pkg::STEP_W-1:0];
    s_first  = LW_W'(s0_q) + ((rem_q == '0) ? '0 : LW_W'(st_eff - rem_q));
    s_next   = s_q + LW_W'(st_eff);
    last_run = s_next > LW_W'(send_q);
  end

  icw_coh_unit u_coh (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (coh_start),
    .sums_i  (sums_q),
    .done_o  (coh_done),
    .res_o   (coh_res)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= icw_pkg::T_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // next state and handshakes
  always_comb begin
    st_d           = st_q;
    sample_i.ready = 1'b0;
    result_o.valid = 1'b0;
    ram_re         = 1'b0;
    ram_we         = 1'b0;
    coh_start      = 1'b0;
    unique case (st_q)
      icw_pkg::T_IDLE: begin
        sample_i.ready = 1'b1;
        if (sample_i.valid) begin
          ram_re = 1'b1;
          st_d   = icw_pkg::T_MUL;
        end
      end
      icw_pkg::T_MUL: st_d = icw_pkg::T_ACC;
      icw_pkg::T_ACC: begin
        ram_we = 1'b1;
        st_d   = plan_emit ? icw_pkg::T_MOD : icw_pkg::T_IDLE;
      end
      icw_pkg::T_MOD: begin
        if (mbit_q == '0) st_d = icw_pkg::T_FIRST;
      end
      icw_pkg::T_FIRST: begin
        st_d = (s_first > LW_W'(send_q)) ? icw_pkg::T_IDLE : icw_pkg::T_SUM;
      end
      icw_pkg::T_SUM: begin
        if (idx_q == c_q) st_d = icw_pkg::T_START;
      end
      icw_pkg::T_START: begin
        coh_start = 1'b1;
        st_d      = icw_pkg::T_WAIT;
      end
      icw_pkg::T_WAIT: begin
        if (coh_done) st_d = icw_pkg::T_OUT;
      end
      icw_pkg::T_OUT: begin
        result_o.valid = 1'b1;
        if (result_o.ready) begin
          st_d = last_run ? icw_pkg::T_IDLE : icw_pkg::T_SUM;
        end
      end
      default: st_d = icw_pkg::T_IDLE;
    endcase
  end

  // line position, block start flag and recent column totals
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
      for (int k = 0; k < NREC; k++) begin
        rec_q[k] <= '0;
      end
    end else if (st_q == icw_pkg::T_ACC) begin
      rec_q[c_q[RW-1:0]] <= tot;
      if (c1 >= w_eff) begin
        col_q   <= '0;
        first_q <= smp_q.final_row;
      end else begin
        col_q <= COL_W'(c1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      icw_pkg::T_IDLE: begin
        if (sample_i.valid) begin
          smp_q <= sample_i.data;
          c_q   <= c_sel;
        end
      end
      icw_pkg::T_MUL: begin
        xr_t_q <= icw_pkg::TERM_W'(m_rr) + icw_pkg::TERM_W'(m_ii);
        xi_t_q <= icw_pkg::TERM_W'(m_ir) - icw_pkg::TERM_W'(m_ri);
        p1_t_q <= $unsigned(m_aa) + $unsigned(m_ab);
        p2_t_q <= $unsigned(m_bb) + $unsigned(m_bi);
      end
      icw_pkg::T_ACC: begin
        s0_q   <= plan_s0;
        send_q <= plan_send;
        rem_q  <= '0;
        mbit_q <= MBIT_W'(COL_W - 1);
      end
      icw_pkg::T_MOD: begin
        rem_q <= rem_n;
        if (mbit_q != '0) mbit_q <= mbit_q - 1'b1;
      end
      icw_pkg::T_FIRST: begin
        s_q    <= s_first;
        idx_q  <= COL_W'(s_first);
        sums_q <= '0;
      end
      icw_pkg::T_SUM: begin
        sums_q.cross_real <= sums_q.cross_real +
          {{RW{rec_q[idx_q[RW-1:0]].cross_real[icw_pkg::CROSS_W-1]}},
           rec_q[idx_q[RW-1:0]].cross_real};
        sums_q.cross_imag <= sums_q.cross_imag +
          {{RW{rec_q[idx_q[RW-1:0]].cross_imag[icw_pkg::CROSS_W-1]}},
           rec_q[idx_q[RW-1:0]].cross_imag};
        sums_q.power_first  <= sums_q.power_first +
          icw_pkg::WSUM_POWER_W'(rec_q[idx_q[RW-1:0]].power_first);
        sums_q.power_second <= sums_q.power_second +
          icw_pkg::WSUM_POWER_W'(rec_q[idx_q[RW-1:0]].power_second);
        if (idx_q != c_q) idx_q <= idx_q + 1'b1;
      end
      icw_pkg::T_OUT: begin
        if (result_o.ready && !last_run) begin
          s_q    <= s_next;
          idx_q  <= COL_W'(s_next);
          sums_q <= '0;
        end
      end
      default: ;
    endcase
  end

  // result payload
  always_comb begin
    result_o.data.coherence   = coh_res.q;
    result_o.data.out_column  = COL_W'(s_q);
    result_o.data.over_one    = coh_res.over;
    result_o.data.last_of_run = last_run;
  end

endmodule
`default_nettype wire

[sv/icw_checker.sv]
// port level checks of the coherence window block and their binding
`default_nettype none
module icw_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input icw_pkg::result_t out_data
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no sample is taken while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready)
    else $error("sample taken during result transfer");

  // a sample transfer starts work that blocks the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("sample accepted back to back");

  // coherence never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.coherence <= icw_pkg::ONE_Q15)
    else $error("coherence above one");

  // a clamped result reads exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.over_one |-> out_data.coherence == icw_pkg::ONE_Q15)
    else $error("clamp flag without full coherence");

endmodule

bind interferogram_coherence_window icw_checker u_icw_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (sample_i.valid),
  .in_ready  (sample_i.ready),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_data  (result_o.data)
);
`default_nettype wire

[tb/interferogram_coherence_window_test.sv]
// self-checking testbench for the boxcar coherence window block
`default_nettype none
module interferogram_coherence_window_test;
  import icw_pkg::*;

  typedef logic [191:0] wide_t;

  localparam longint SUM_TOP = 64'sd549755813887;
  localparam longint SUM_BOT = -SUM_TOP - 1;
  localparam int WATCHDOG_LIMIT = 20000;

  // predicts results from accepted samples and checks the block's output against them
  class coherence_scoreboard;
    int unsigned line_width = 1024, look_samples = 3, step_samples = 1;
    longint col_xr[MAX_LINE_SAMPLES], col_xi[MAX_LINE_SAMPLES];
    longint col_p1[MAX_LINE_SAMPLES], col_p2[MAX_LINE_SAMPLES];
    longint rec_xr[MAX_WINDOW_SAMPLES], rec_xi[MAX_WINDOW_SAMPLES];
    longint rec_p1[MAX_WINDOW_SAMPLES], rec_p2[MAX_WINDOW_SAMPLES];
    int unsigned column_pos = 0;
    bit block_start = 1;
    result_t awaited[$];
    int errors = 0, samples = 0, results = 0, clamped = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
      if (idx == CFG_LINE_WIDTH) line_width = val & 13'h1fff;
      else if (idx == CFG_LOOK_SAMPLES) look_samples = val & 5'h1f;
      else if (idx == CFG_STEP_SAMPLES) step_samples = val & 5'h1f;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function longint sat_signed(longint v);
      return v > SUM_TOP ? SUM_TOP : (v < SUM_BOT ? SUM_BOT : v);
    endfunction

    function longint sat_power(longint v);
      return v > SUM_TOP ? SUM_TOP : (v < 0 ? 64'sd0 : v);
    endfunction

    // exact coherence in Q1.15, truncated, with the above-one clamp
    function void coherence_q15(longint sr, longint si, longint p1, longint p2,
                                output logic [Q_W-1:0] q, output logic ov);
      wide_t num, den, rhs, mr, mi, t;
      logic [14:0] acc;
      q = '0;
      ov = 1'b0;
      if (p1 <= 0 || p2 <= 0) return;
      mr = wide_t'(sr < 0 ? -sr : sr);
      mi = wide_t'(si < 0 ? -si : si);
      num = mr * mr + mi * mi;
      den = wide_t'(p1) * wide_t'(p2);
      if (num * wide_t'(OVER_NUM_K) > den * wide_t'(OVER_DEN_K)) begin
        q = ONE_Q15;
        ov = 1'b1;
        return;
      end
      rhs = num << 30;
      if ((den << 30) <= rhs) begin
        q = ONE_Q15;
        return;
      end
      acc = '0;
      for (int b = 14; b >= 0; b--) begin
        t = wide_t'(acc | (15'd1 << b));
        if (den * t * t <= rhs) acc = acc | (15'd1 << b);
      end
      q = {1'b0, acc};
    endfunction

    function result_t window_result(int unsigned s, int unsigned e);
      longint sr = 0, si = 0, p1 = 0, p2 = 0;
      result_t r;
      for (int unsigned c = s; c <= e; c++) begin
        sr += rec_xr[c % MAX_WINDOW_SAMPLES];
        si += rec_xi[c % MAX_WINDOW_SAMPLES];
        p1 += rec_p1[c % MAX_WINDOW_SAMPLES];
        p2 += rec_p2[c % MAX_WINDOW_SAMPLES];
      end
      coherence_q15(sr, si, p1, p2, r.coherence, r.over_one);
      r.out_column = COL_W'(s);
      r.last_of_run = 1'b0;
      return r;
    endfunction

    // column update and window emission for one accepted sample
    function void note_sample(sample_t smp);
      int unsigned w = line_width, l = look_samples, st = step_samples, c, i, s;
      longint ar, ai, br, bi, xr, xi, p1, p2;
      result_t batch[$];
      ar = longint'($signed(smp.first_real));
      ai = longint'($signed(smp.first_imag));
      br = longint'($signed(smp.second_real));
      bi = longint'($signed(smp.second_imag));
      samples++;
      if (w == 0) w = 1;
      if (w > MAX_LINE_SAMPLES) w = MAX_LINE_SAMPLES;
      if (l == 0) l = 1;
      if (l > MAX_WINDOW_SAMPLES) l = MAX_WINDOW_SAMPLES;
      if (st == 0) st = 1;
      if (column_pos >= w) column_pos = 0;
      c = column_pos;
      xr = ar * br + ai * bi;
      xi = ai * br - ar * bi;
      p1 = ar * ar + ai * ai;
      p2 = br * br + bi * bi;
      if (!block_start) begin
        xr += col_xr[c];
        xi += col_xi[c];
        p1 += col_p1[c];
        p2 += col_p2[c];
      end
      col_xr[c] = sat_signed(xr);
      col_xi[c] = sat_signed(xi);
      col_p1[c] = sat_power(p1);
      col_p2[c] = sat_power(p2);
      i = c % MAX_WINDOW_SAMPLES;
      rec_xr[i] = col_xr[c];
      rec_xi[i] = col_xi[c];
      rec_p1[i] = col_p1[c];
      rec_p2[i] = col_p2[c];
      if (smp.final_row) begin
        if (c + 1 < w) begin
          if (c + 1 >= l && (c + 1 - l) % st == 0) batch.push_back(window_result(c + 1 - l, c));
        end else begin
          for (s = (w > l) ? w - l : 0; s < w; s++)
            if (s % st == 0) batch.push_back(window_result(s, c));
        end
        if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
        foreach (batch[k]) awaited.push_back(batch[k]);
      end
      if (c + 1 >= w) begin
        column_pos = 0;
        block_start = smp.final_row;
      end else begin
        column_pos = c + 1;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      results++;
      if (got.over_one) clamped++;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, got);
        errors++;
        return;
      end
      exp_r = awaited.pop_front();
      if (got.coherence !== exp_r.coherence) begin
        $display("%0t: coherence expected %0d actual %0d", $time, exp_r.coherence, got.coherence);
        errors++;
      end
      if (got.out_column !== exp_r.out_column) begin
        $display("%0t: out_column expected %0d actual %0d", $time, exp_r.out_column,
                 got.out_column);
        errors++;
      end
      if (got.over_one !== exp_r.over_one) begin
        $display("%0t: over_one expected %0b actual %0b", $time, exp_r.over_one, got.over_one);
        errors++;
      end
      if (got.last_of_run !== exp_r.last_of_run) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, exp_r.last_of_run,
                 got.last_of_run);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  icw_sample_if sample_ch ();
  icw_result_if result_ch ();

  coherence_scoreboard sb = new();
  int burst_left = 0;
  int idle_count = 0;
  bit hold_req = 1'b0;

  interferogram_coherence_window uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_ch),
    .result_o    (result_ch)
  );

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  // transfer monitors feed the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni && sample_ch.valid && sample_ch.ready) sb.note_sample(sample_ch.data);
    if (rst_ni && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count == WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
      $display("[interferogram_coherence_window] ERROR");
      $finish;
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin : receiver
    int hold_cnt;
    int cyc;
    int mode;
    hold_cnt = 0;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = 600;
      end
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        result_ch.ready = 1'b0;
      end else begin
        case (mode)
          0: result_ch.ready = 1'b1;
          1: result_ch.ready = (cyc % 3 == 0);
          2: result_ch.ready = $urandom_range(0, 1);
          default: result_ch.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_window(int unsigned w, int unsigned l, int unsigned st);
    write_reg(CFG_LINE_WIDTH, w);
    write_reg(CFG_LOOK_SAMPLES, l);
    write_reg(CFG_STEP_SAMPLES, st);
  endtask

  // offer one sample in bursts with random gaps, returning after its transfer
  task automatic send_sample(sample_t smp);
    if (burst_left == 0) begin
      sample_ch.valid = 1'b0;
      repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    sample_ch.valid = 1'b1;
    sample_ch.data = smp;
    @(posedge clk_i);
    while (!sample_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
  endtask

  // wait until all results are in and the block has settled
  task automatic drain();
    sample_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_value(int mode);
    case (mode)
      0: return 16'($urandom());
      1: case ($urandom_range(0, 4))
           0: return 16'h8000;
           1: return 16'h7fff;
           2: return 16'h0000;
           3: return 16'hffff;
           default: return 16'h0001;
         endcase
      default: return 16'h0000;
    endcase
  endfunction

  function automatic sample_t make_sample(int mode, logic fin);
    sample_t smp;
    smp.first_real = pick_value(mode);
    smp.first_imag = pick_value(mode);
    smp.second_real = pick_value(mode);
    smp.second_imag = pick_value(mode);
    smp.final_row = fin;
    return smp;
  endfunction

  function automatic sample_t make_pair(logic [15:0] ar, logic [15:0] ai,
                                        logic [15:0] br, logic [15:0] bi, logic fin);
    sample_t smp;
    smp.first_real = ar;
    smp.first_imag = ai;
    smp.second_real = br;
    smp.second_imag = bi;
    smp.final_row = fin;
    return smp;
  endfunction

  // one complete row; the closing sample of the last row always carries the flag
  task automatic send_row(int unsigned w, int mode, bit last_row);
    logic fin;
    for (int unsigned c = 0; c < w; c++) begin
      if (last_row) fin = (c == w - 1) || ($urandom_range(0, 9) != 0);
      else fin = ($urandom_range(0, 9) == 0);
      send_sample(make_sample(mode, fin));
    end
  endtask

  initial begin : stimulus
    int unsigned w, rows, random_items;
    int mode;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // truncated windows at the right edge, extreme values
    set_window(5, 3, 2);
    for (int c = 0; c < 5; c++) send_sample(make_sample(1, 1'b1));
    drain();

    // zero power, then identical images at exactly one
    set_window(3, 1, 1);
    for (int c = 0; c < 3; c++) send_sample(make_sample(2, 1'b1));
    for (int c = 0; c < 3; c++)
      send_sample(make_pair(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1));
    drain();

    // zero registers act as one
    set_window(0, 0, 0);
    send_sample(make_sample(0, 1'b0));
    send_sample(make_sample(0, 1'b1));
    drain();

    // line shortened while the position lies past its end; look above the maximum
    set_window(8, 31, 16);
    for (int c = 0; c < 5; c++) send_sample(make_sample(0, 1'b0));
    drain();
    write_reg(CFG_LINE_WIDTH, 3);
    for (int c = 0; c < 3; c++) send_sample(make_sample(0, 1'b1));
    drain();

    // line width clamped from the register maximum, widest look and step
    set_window(8191, 16, 31);
    for (int c = 0; c < 20; c++) send_sample(make_sample(0, 1'b1));
    drain();

    // random blocks, with one long receiver hold-off
    random_items = 0;
    hold_req = 1'b1;
    while (random_items < 180) begin
      w = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 12);
      set_window(w, $urandom_range(0, 31),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 3));
      rows = $urandom_range(1, 4);
      mode = ($urandom_range(0, 4) == 0) ? 1 : 0;
      for (int unsigned r = 0; r < rows; r++) send_row(w, mode, r == rows - 1);
      random_items += w * rows;
      drain();
    end

    repeat (50) @(negedge clk_i);
    $display("covered %0d samples and %0d results, %0d of them clamped above one",
             sb.samples, sb.results, sb.clamped);
    $display("line widths 0 to 8191, looks 0 to 31, steps 0 to 31, stalls and a long hold-off");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[interferogram_coherence_window] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
      $display("[interferogram_coherence_window] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

[files.f]
sv/icw_pkg.sv
sv/icw_sample_if.sv
sv/icw_result_if.sv
sv/icw_column_ram.sv
sv/icw_serial_mul.sv
sv/icw_coh_unit.sv
sv/interferogram_coherence_window.sv
sv/icw_checker.sv
tb/interferogram_coherence_window_test.sv
